/* design/psadpcm_pkg.sv */
// ----------------------------------------------------------------------------
// PS-ADPCM block decoder package
// Shared word types, controller/datapath command and status, filter table.
// ----------------------------------------------------------------------------
package psadpcm_pkg;

  // Byte positions within a 16-byte block.
  localparam logic [3:0] IdxHeader = 4'd0;
  localparam logic [3:0] IdxFlags  = 4'd1;

  // Header limits.
  localparam logic [3:0] ShiftLimit = 4'd12;
  localparam logic [3:0] FilterMax  = 4'd4;

  // Prediction coefficients carry six fraction bits.
  localparam int CoefShift = 6;
  localparam int CoefRound = 32;

  // Output clamp.
  localparam int PcmMax = 32767;
  localparam int PcmMin = -32768;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       channel;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               out_channel;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic acc;
    logic emit;
    logic nib_hi;
  } dp_cmd_t;

  typedef struct packed {
    logic decode;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [7:0] coef_one(logic [2:0] filt);
    logic signed [7:0] k;
    unique case (filt)
      3'd1:    k = 8'sd60;
      3'd2:    k = 8'sd115;
      3'd3:    k = 8'sd98;
      3'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [7:0] coef_two(logic [2:0] filt);
    logic signed [7:0] k;
    unique case (filt)
      3'd2:    k = -8'sd52;
      3'd3:    k = -8'sd55;
      3'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

endpackage

/* design/psadpcm_if.sv */
// ----------------------------------------------------------------------------
// PS-ADPCM stream interfaces
// Valid/ready channels for input bytes and decoded samples.
// ----------------------------------------------------------------------------
interface psadpcm_in_if;
  import psadpcm_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psadpcm_out_if;
  import psadpcm_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/psadpcm_ctrl.sv */
// ----------------------------------------------------------------------------
// PS-ADPCM controller
// Sequences the two nibble decodes of a byte through the datapath.
// ----------------------------------------------------------------------------
module psadpcm_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  psadpcm_pkg::dp_status_t status_i,
  output logic                    in_ready_o,
  output psadpcm_pkg::dp_cmd_t    cmd_o
);
  import psadpcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   nib_q;
  logic   accept;

  assign accept = in_valid_i & in_ready_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.mul    = (state_q == S_MUL);
    cmd_o.acc    = (state_q == S_ACC);
    cmd_o.emit   = (state_q == S_EMIT) & status_i.out_free;
    cmd_o.nib_hi = nib_q;
  end

  assign in_ready_o = in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
      nib_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && status_i.decode) begin
            state_q    <= S_MUL;
            in_ready_q <= 1'b0;
            nib_q      <= 1'b0;
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (status_i.out_free) begin
            if (nib_q) begin
              state_q    <= S_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= S_MUL;
              nib_q   <= 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/psadpcm_dp.sv */
// ----------------------------------------------------------------------------
// PS-ADPCM datapath
// Channel state, two-tap prediction, saturation, rounding and output word.
// ----------------------------------------------------------------------------
module psadpcm_dp #(
  parameter int CHANNELS      = 2,
  parameter int FRACTION_BITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psadpcm_pkg::dp_cmd_t    cmd_i,
  input  psadpcm_pkg::in_word_t   in_data_i,
  output psadpcm_pkg::dp_status_t status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output psadpcm_pkg::out_word_t  out_data_o
);
  import psadpcm_pkg::*;

  localparam int HW   = 20 + FRACTION_BITS;
  localparam int PW   = HW + 8;
  localparam int VW   = HW + 4;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [HW-1:0] HistMax = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HistMin = {1'b1, {(HW-1){1'b0}}};
  localparam int RoundHalf = 1 << (FRACTION_BITS - 1);

  logic signed [HW-1:0] hist1_q [CHANNELS];
  logic signed [HW-1:0] hist2_q [CHANNELS];
  logic        [3:0]    shift_q [CHANNELS];
  logic        [2:0]    filt_q  [CHANNELS];

  logic [7:0]      byte_q;
  logic [CH_W-1:0] ch_q;
  logic            chan_q;

  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [HW-1:0] resid_q;
  logic signed [HW-1:0] val_q;

  logic      out_valid_q;
  out_word_t out_q;

  // Input side decode.
  logic            in_ch_ok;
  logic [CH_W-1:0] in_idx;
  logic [3:0]      hdr_filt;

  assign in_ch_ok = (int'(in_data_i.channel) < CHANNELS);
  assign in_idx   = CH_W'(in_data_i.channel);
  assign hdr_filt = in_data_i.data_byte[7:4];

  assign status_o.decode   = in_ch_ok && (in_data_i.byte_index != IdxHeader)
                             && (in_data_i.byte_index != IdxFlags);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Residual and products for the current nibble.
  logic [3:0]           nib;
  logic [3:0]           shift_eff;
  logic [4:0]           shamt;
  logic signed [HW-1:0] resid_d;
  logic signed [PW-1:0] p1_d, p2_d;

  always_comb begin
    nib       = cmd_i.nib_hi ? byte_q[7:4] : byte_q[3:0];
    shift_eff = (shift_q[ch_q] > ShiftLimit) ? ShiftLimit : shift_q[ch_q];
    shamt     = 5'(FRACTION_BITS + 12) - {1'b0, shift_eff};
    resid_d   = HW'($signed(nib)) <<< shamt;
    p1_d      = PW'(hist1_q[ch_q]) * PW'(coef_one(filt_q[ch_q]));
    p2_d      = PW'(hist2_q[ch_q]) * PW'(coef_two(filt_q[ch_q]));
  end

  // Prediction sum, residual add and saturation.
  logic signed [PW:0]   acc_sum;
  logic signed [PW:0]   acc_sh;
  logic signed [VW-1:0] val_w;
  logic signed [HW-1:0] val_d;

  always_comb begin
    acc_sum = (PW+1)'(p1_q) + (PW+1)'(p2_q) + (PW+1)'(CoefRound);
    acc_sh  = acc_sum >>> CoefShift;
    val_w   = VW'(acc_sh) + VW'(resid_q);
    if (val_w > VW'(HistMax)) begin
      val_d = HistMax;
    end else if (val_w < VW'(HistMin)) begin
      val_d = HistMin;
    end else begin
      val_d = val_w[HW-1:0];
    end
  end

  // Rounding to integer and clamp to 16 bits.
  logic signed [HW:0] rnd;
  logic signed [HW:0] pcm_w;
  logic signed [15:0] pcm_d;

  always_comb begin
    rnd   = (HW+1)'(val_q) + (HW+1)'(RoundHalf);
    pcm_w = rnd >>> FRACTION_BITS;
    if (pcm_w > (HW+1)'(PcmMax)) begin
      pcm_d = 16'sh7FFF;
    end else if (pcm_w < (HW+1)'(PcmMin)) begin
      pcm_d = -16'sh8000;
    end else begin
      pcm_d = pcm_w[15:0];
    end
  end

  // Channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hist1_q[i] <= '0;
        hist2_q[i] <= '0;
        shift_q[i] <= '0;
        filt_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.accept && in_ch_ok) begin
        if (in_data_i.restart) begin
          hist1_q[in_idx] <= '0;
          hist2_q[in_idx] <= '0;
        end
        if (in_data_i.byte_index == IdxHeader) begin
          shift_q[in_idx] <= in_data_i.data_byte[3:0];
          filt_q[in_idx]  <= (hdr_filt > FilterMax) ? 3'd0 : hdr_filt[2:0];
        end
      end else if (cmd_i.acc) begin
        hist2_q[ch_q] <= hist1_q[ch_q];
        hist1_q[ch_q] <= val_d;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i.data_byte;
      ch_q   <= in_idx;
      chan_q <= in_data_i.channel;
    end
    if (cmd_i.mul) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      resid_q <= resid_d;
    end
    if (cmd_i.acc) begin
      val_q <= val_d;
    end
    if (cmd_i.emit) begin
      out_q.pcm_sample  <= pcm_d;
      out_q.out_channel <= chan_q;
      out_q.last        <= cmd_i.nib_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/ps_adpcm_block_decoder.sv */
// ----------------------------------------------------------------------------
// PS-ADPCM block decoder
// Decodes 16-byte ADPCM blocks, one byte per input word, for several channels.
// ----------------------------------------------------------------------------
// The input channel carries one block byte per word with its position in the
// block, its channel and a restart flag that clears that channel's history.
// A header byte (position 0) loads the channel's shift and filter and a flags
// byte (position 1) is dropped; neither yields any output.
// Every other byte yields two output words, the low-nibble sample first and
// the high-nibble sample second, marked by last. Bytes for a channel at or
// above CHANNELS are ignored.
// Each sample runs through three steps of the datapath: the two prediction
// products, then the add and saturate that update the history, then the
// rounding and clamp into the output register. The two samples of a byte
// depend on each other, so the decoder takes no new byte until the second
// sample of the current one has entered the output register.
// The output register lets the next byte enter while the last sample waits;
// if the receiver stalls, the decoder holds the pending sample and waits.
// Reset clears history, shift and filter of all channels at once.
// ----------------------------------------------------------------------------
module ps_adpcm_block_decoder #(
  parameter int CHANNELS      = 2,
  parameter int FRACTION_BITS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  psadpcm_in_if.sink    in_i,
  psadpcm_out_if.source out_o
);
  import psadpcm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns the input handshake and the sample sequence.
  psadpcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // The datapath keeps per-channel state and the output register.
  psadpcm_dp #(
    .CHANNELS      (CHANNELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule
